FILE: src/cht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and codes of the cubic Hermite interpolator: item kinds,
// result status codes, the queued work item and the result record.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int IDX_W  = 4;
  localparam int VAL_W  = 32;
  localparam int TIME_W = 31;

  typedef enum logic [2:0] {
    K_LOAD     = 3'd0,
    K_EVAL     = 3'd1,
    K_REJECT   = 3'd2,
    K_SKIP     = 3'd3,
    K_EVAL_OOB = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_SAT    = 2'd2
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [IDX_W-1:0]   idx;
    logic [32:0]        diff_a;  // q0 - qh
    logic [32:0]        sum_a;   // dq0 + dqh
    logic [34:0]        diff_b;  // 3 * (qh - q0)
    logic [34:0]        nsum_b;  // -(2 * dq0 + dqh)
    logic [VAL_W-1:0]   q0;
    logic [VAL_W-1:0]   dq0;
    logic [TIME_W-1:0]  tm;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    status_e          status;
  } res_t;

endpackage
`default_nettype wire

FILE: src/cht_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_fifo
// Small first-in first-out queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module cht_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

FILE: src/cht_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_front
// Classifies an incoming item (load, evaluate, rejected load, out-of-table
// access) and forms the differences and sums that the load arithmetic needs.
// ----------------------------------------------------------------------------
module cht_front #(
  parameter int ENTRIES = 16
) (
  input  logic                 func_i,
  input  logic [3:0]           index_i,
  input  logic signed [31:0]   start_value_i,
  input  logic signed [31:0]   start_slope_i,
  input  logic signed [31:0]   end_value_i,
  input  logic signed [31:0]   end_slope_i,
  input  logic [30:0]          step_time_i,
  output cht_pkg::item_t       item_o
);

  import cht_pkg::*;

  logic        in_range;
  logic [32:0] dv;
  logic [34:0] sb;

  assign in_range = (int'(index_i) < ENTRIES);

  always_comb begin
    dv = {end_value_i[31], end_value_i} - {start_value_i[31], start_value_i};
    sb = {{2{start_slope_i[31]}}, start_slope_i, 1'b0}
       + {{3{end_slope_i[31]}}, end_slope_i};
    item_o.idx    = index_i;
    item_o.diff_a = {start_value_i[31], start_value_i} - {end_value_i[31], end_value_i};
    item_o.sum_a  = {start_slope_i[31], start_slope_i} + {end_slope_i[31], end_slope_i};
    item_o.diff_b = {{2{dv[32]}}, dv} + {dv[32], dv, 1'b0};
    item_o.nsum_b = '0 - sb;
    item_o.q0     = start_value_i;
    item_o.dq0    = start_slope_i;
    item_o.tm     = step_time_i;
    if (!func_i) begin
      if (step_time_i == '0) begin
        item_o.kind = K_REJECT;
      end else if (in_range) begin
        item_o.kind = K_LOAD;
      end else begin
        item_o.kind = K_SKIP;
      end
    end else begin
      item_o.kind = in_range ? K_EVAL : K_EVAL_OOB;
    end
  end

endmodule
`default_nettype wire

FILE: src/cht_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_div
// Restoring radix-2 divider, one quotient bit a cycle over 64 bits, with
// sign restore and saturation of the quotient to the signed 64-bit range.
// ----------------------------------------------------------------------------
module cht_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         neg_i,
  input  logic [115:0] mag_i,
  input  logic [92:0]  den_i,
  output logic         done_o,
  output logic [63:0]  quot_o
);

  logic [92:0] rem_q, rem_d;
  logic [92:0] den_q;
  logic [63:0] lo_q, lo_d;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q, big_q, neg_q;
  logic [93:0] rem2;
  logic        ge;

  assign rem2 = {rem_q, lo_q[63]};
  assign ge   = (rem2 >= {1'b0, den_q});

  always_comb begin
    rem_d = ge ? 93'(rem2 - {1'b0, den_q}) : rem2[92:0];
    lo_d  = {lo_q[62:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {41'b0, mag_i[115:64]};
      lo_q  <= mag_i[63:0];
      den_q <= den_i;
      neg_q <= neg_i;
      big_q <= ({41'b0, mag_i[115:64]} >= den_i);
    end else if (busy_q) begin
      rem_q <= rem_d;
      lo_q  <= lo_d;
    end
  end

  assign done_o = done_q;

  always_comb begin
    if (!neg_q) begin
      quot_o = (big_q || lo_q[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : lo_q;
    end else if (big_q || (lo_q[63] && (|lo_q[62:0]))) begin
      quot_o = 64'h8000_0000_0000_0000;
    end else begin
      quot_o = '0 - lo_q;
    end
  end

endmodule
`default_nettype wire

FILE: src/cht_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_back
// Executes queued items: a shared 35x33 multiplier with a wide accumulator
// forms powers of time, numerators and the cubic sum; the divider forms the
// cubic and quadratic coefficients; the coefficient memory is kept here.
// ----------------------------------------------------------------------------
module cht_back #(
  parameter int ENTRIES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_empty_i,
  input  cht_pkg::item_t in_item_i,
  output logic           in_pop_o,
  input  logic           out_full_i,
  output logic           out_push_o,
  output cht_pkg::res_t  out_res_o
);

  import cht_pkg::*;

  localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ACC_W = 160;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_POW  = 8'b0000_0010,
    S_NUMA = 8'b0000_0100,
    S_DIVA = 8'b0000_1000,
    S_NUMB = 8'b0001_0000,
    S_DIVB = 8'b0010_0000,
    S_MAC  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  typedef enum logic [3:0] {
    A_T, A_P2LO, A_P2HI, A_SUMA, A_NSUMB, A_ALO, A_AHI, A_BLO, A_BHI, A_C
  } asel_e;

  typedef enum logic [2:0] {
    B_T, B_P30, B_P31, B_P32, B_P2LO, B_P2HI
  } bsel_e;

  typedef enum logic [2:0] {
    I_ACC, I_ZERO, I_NUMA, I_NUMB, I_EVAL
  } init_e;

  typedef struct packed {
    asel_e      a;
    bsel_e      b;
    logic [2:0] sh;
    init_e      init;
    logic       cap2;
    logic       cap3;
  } op_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } coef_t;

  state_e             state_q, state_d;
  logic [3:0]         step_q, step_d;
  item_t              cur_q;
  res_t               res_q;
  logic [ACC_W-1:0]   acc_q, acc_d, base, prod_ext;
  logic [63:0]        pw2_q;
  logic [95:0]        pw3_q;
  logic [63:0]        a_q;
  logic               dstart_q;
  coef_t              mem_q [ENTRIES];
  coef_t              rd_q;
  op_t                op;
  logic               mul_en;
  logic signed [34:0] ma;
  logic signed [32:0] mb;
  logic signed [67:0] prod;
  logic               div_done;
  logic [63:0]        div_quot;
  logic [ACC_W-1:0]   acc_mag;
  logic [92:0]        den;
  logic               ovf;
  logic [31:0]        ev_value;

  // micro-op selection
  always_comb begin
    op     = '{a: A_T, b: B_T, sh: 3'd0, init: I_ACC, cap2: 1'b0, cap3: 1'b0};
    mul_en = 1'b1;
    case (state_q)
      S_POW: begin
        case (step_q)
          4'd0: op = '{a: A_T,    b: B_T, sh: 3'd0, init: I_ZERO, cap2: 1'b1, cap3: 1'b0};
          4'd1: op = '{a: A_P2LO, b: B_T, sh: 3'd0, init: I_ZERO, cap2: 1'b0, cap3: 1'b0};
          default: op = '{a: A_P2HI, b: B_T, sh: 3'd2, init: I_ACC, cap2: 1'b0, cap3: 1'b1};
        endcase
      end
      S_NUMA: op = '{a: A_SUMA,  b: B_T, sh: 3'd3, init: I_NUMA, cap2: 1'b0, cap3: 1'b0};
      S_NUMB: op = '{a: A_NSUMB, b: B_T, sh: 3'd2, init: I_NUMB, cap2: 1'b0, cap3: 1'b0};
      S_MAC: begin
        case (step_q)
          4'd0: op = '{a: A_ALO, b: B_P30,  sh: 3'd0, init: I_EVAL, cap2: 1'b0, cap3: 1'b0};
          4'd1: op = '{a: A_ALO, b: B_P31,  sh: 3'd2, init: I_ACC, cap2: 1'b0, cap3: 1'b0};
          4'd2: op = '{a: A_ALO, b: B_P32,  sh: 3'd4, init: I_ACC, cap2: 1'b0, cap3: 1'b0};
          4'd3: op = '{a: A_AHI, b: B_P30,  sh: 3'd2, init: I_ACC, cap2: 1'b0, cap3: 1'b0};
          4'd4: op = '{a: A_AHI, b: B_P31,  sh: 3'd4, init: I_ACC, cap2: 1'b0, cap3: 1'b0};
          4'd5: op = '{a: A_AHI, b: B_P32,  sh: 3'd6, init: I_ACC, cap2: 1'b0, cap3: 1'b0};
          4'd6: op = '{a: A_BLO, b: B_P2LO, sh: 3'd1, init: I_ACC, cap2: 1'b0, cap3: 1'b0};
          4'd7: op = '{a: A_BLO, b: B_P2HI, sh: 3'd3, init: I_ACC, cap2: 1'b0, cap3: 1'b0};
          4'd8: op = '{a: A_BHI, b: B_P2LO, sh: 3'd3, init: I_ACC, cap2: 1'b0, cap3: 1'b0};
          4'd9: op = '{a: A_BHI, b: B_P2HI, sh: 3'd5, init: I_ACC, cap2: 1'b0, cap3: 1'b0};
          default: op = '{a: A_C, b: B_T, sh: 3'd3, init: I_ACC, cap2: 1'b0, cap3: 1'b0};
        endcase
      end
      default: mul_en = 1'b0;
    endcase
  end

  // operand selection
  always_comb begin
    case (op.a)
      A_T:     ma = {4'b0, cur_q.tm};
      A_P2LO:  ma = {3'b0, pw2_q[31:0]};
      A_P2HI:  ma = {3'b0, pw2_q[63:32]};
      A_SUMA:  ma = {{2{cur_q.sum_a[32]}}, cur_q.sum_a};
      A_NSUMB: ma = cur_q.nsum_b;
      A_ALO:   ma = {3'b0, rd_q.a[31:0]};
      A_AHI:   ma = {{3{rd_q.a[63]}}, rd_q.a[63:32]};
      A_BLO:   ma = {3'b0, rd_q.b[31:0]};
      A_BHI:   ma = {{3{rd_q.b[63]}}, rd_q.b[63:32]};
      A_C:     ma = {{3{rd_q.c[31]}}, rd_q.c};
      default: ma = '0;
    endcase
    case (op.b)
      B_T:     mb = {2'b0, cur_q.tm};
      B_P30:   mb = {1'b0, pw3_q[31:0]};
      B_P31:   mb = {1'b0, pw3_q[63:32]};
      B_P32:   mb = {1'b0, pw3_q[95:64]};
      B_P2LO:  mb = {1'b0, pw2_q[31:0]};
      B_P2HI:  mb = {1'b0, pw2_q[63:32]};
      default: mb = '0;
    endcase
    case (op.init)
      I_ZERO:  base = '0;
      I_NUMA:  base = {{62{cur_q.diff_a[32]}}, cur_q.diff_a, 65'b0};
      I_NUMB:  base = {{77{cur_q.diff_b[34]}}, cur_q.diff_b, 48'b0};
      I_EVAL:  base = {{64{rd_q.d[31]}}, rd_q.d, 1'b1, 63'b0};
      default: base = acc_q;
    endcase
  end

  assign prod     = ma * mb;
  assign prod_ext = {{(ACC_W-68){prod[67]}}, prod};
  assign acc_d    = base + (prod_ext << {op.sh, 4'b0000});

  // divider operands
  assign acc_mag = acc_q[ACC_W-1] ? ('0 - acc_q) : acc_q;
  assign den     = (state_q == S_DIVA) ? pw3_q[92:0] : {31'b0, pw2_q[61:0]};

  cht_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dstart_q),
    .neg_i  (acc_q[ACC_W-1]),
    .mag_i  (acc_mag[115:0]),
    .den_i  (den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // sequencing
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (!in_empty_i) begin
          step_d = '0;
          if (in_item_i.kind == K_LOAD || in_item_i.kind == K_EVAL) begin
            state_d = S_POW;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_POW: begin
        if (step_q == 4'd2) begin
          step_d  = '0;
          state_d = (cur_q.kind == K_LOAD) ? S_NUMA : S_MAC;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_NUMA: state_d = S_DIVA;
      S_DIVA: if (div_done) state_d = S_NUMB;
      S_NUMB: state_d = S_DIVB;
      S_DIVB: if (div_done) state_d = S_OUT;
      S_MAC: begin
        if (step_q == 4'd10) begin
          state_d = S_OUT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_OUT: if (!out_full_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_pop_o   = (state_q == S_IDLE) & ~in_empty_i;
  assign out_push_o = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      dstart_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      dstart_q <= (state_q == S_NUMA) | (state_q == S_NUMB);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_pop_o) begin
      cur_q        <= in_item_i;
      res_q.idx    <= in_item_i.idx;
      res_q.value  <= '0;
      res_q.status <= (in_item_i.kind == K_REJECT) ? ST_REJECT : ST_OK;
    end
    if (mul_en) begin
      acc_q <= acc_d;
    end
    if (mul_en && op.cap2) begin
      pw2_q <= acc_d[63:0];
    end
    if (mul_en && op.cap3) begin
      pw3_q <= acc_d[95:0];
    end
    if (state_q == S_DIVA && div_done) begin
      a_q <= div_quot;
    end
  end

  // coefficient memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIVB && div_done) begin
      mem_q[AW'(cur_q.idx)] <= '{a: a_q, b: div_quot, c: cur_q.dq0, d: cur_q.q0};
    end
    rd_q <= mem_q[AW'(cur_q.idx)];
  end

  // evaluate result: round already added, take the integer part and saturate
  assign ovf      = ~((&acc_q[ACC_W-1:95]) | ~(|acc_q[ACC_W-1:95]));
  assign ev_value = ovf ? (acc_q[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : acc_q[95:64];

  always_comb begin
    out_res_o = res_q;
    if (cur_q.kind == K_EVAL) begin
      out_res_o.value  = ev_value;
      out_res_o.status = ovf ? ST_SAT : ST_OK;
    end
  end

endmodule
`default_nettype wire

FILE: src/cubic_hermite_interpolator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_hermite_interpolator_top
// Table of Hermite cubics: a load item stores the coefficients for one index,
// an evaluate item returns the cubic at an elapsed time.
//
// Input side is a queue: the item transfers when push is high and full low.
// Result side is a queue: the oldest result shows while empty is low and
// transfers when pop is high. Every item gives exactly one result, in order.
// A two-entry queue sits between the classifying front and the execution
// back end, and another one holds finished results.
// An evaluate runs 3 power steps and 11 multiply-accumulate steps on the
// shared multiplier; a load runs two divider passes of 64 quotient steps
// each. Rejected loads and out-of-table accesses skip the arithmetic. Items
// run one at a time in the back end: a new item starts only once the last
// has given its result.
// Reset clears all control state; the coefficient table is not cleared.
// When the receiver stalls, results fill the result queue, then the back
// end holds and the input queue fills until full rises.
// ----------------------------------------------------------------------------
module cubic_hermite_interpolator_top #(
  parameter int ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               func_i,
  input  logic [3:0]         index_i,
  input  logic signed [31:0] start_value_i,
  input  logic signed [31:0] start_slope_i,
  input  logic signed [31:0] end_value_i,
  input  logic signed [31:0] end_slope_i,
  input  logic [30:0]        step_time_i,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         result_index_o,
  output logic signed [31:0] value_o,
  output logic [1:0]         status_o
);

  import cht_pkg::*;

  item_t front_item, q_item;
  logic  q_empty, q_pop;
  res_t  back_res, out_res;
  logic  out_full, out_push;
  logic [$bits(item_t)-1:0] q_rdata;
  logic [$bits(res_t)-1:0]  o_rdata;

  cht_front #(.ENTRIES(ENTRIES)) u_front (
    .func_i       (func_i),
    .index_i      (index_i),
    .start_value_i(start_value_i),
    .start_slope_i(start_slope_i),
    .end_value_i  (end_value_i),
    .end_slope_i  (end_slope_i),
    .step_time_i  (step_time_i),
    .item_o       (front_item)
  );

  cht_fifo #(.WIDTH($bits(item_t)), .DEPTH(2)) u_in_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .wdata_i(front_item),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .rdata_o(q_rdata)
  );

  assign q_item = item_t'(q_rdata);

  cht_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_empty_i(q_empty),
    .in_item_i (q_item),
    .in_pop_o  (q_pop),
    .out_full_i(out_full),
    .out_push_o(out_push),
    .out_res_o (back_res)
  );

  cht_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .full_o (out_full),
    .wdata_i(back_res),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(o_rdata)
  );

  assign out_res        = res_t'(o_rdata);
  assign result_index_o = out_res.idx;
  assign value_o        = out_res.value;
  assign status_o       = out_res.status;

endmodule
`default_nettype wire
